### design/tree_bin_lookup_defines.svh
// ----------------------------------------------------------------------------
// tree_bin_lookup_defines.svh
// Assertion macros used by the tree bin lookup walk engine.
// ----------------------------------------------------------------------------
`ifndef TREE_BIN_LOOKUP_DEFINES_SVH
`define TREE_BIN_LOOKUP_DEFINES_SVH

`ifndef ASSERT_OFF
`define TBL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TBL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TBL_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define TBL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### design/tbl_pkg.sv
// ----------------------------------------------------------------------------
// tbl_pkg
// Types and constants shared by the tree bin lookup front end, request
// queue and walk engine.
// ----------------------------------------------------------------------------
package tbl_pkg;

    // Stream widths.
    localparam int IN_DATA_W  = 104;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;
    localparam int BIN_W      = 11;

    // Request type codes carried on the input tuser.
    localparam logic [1:0] REQ_NODE_WR  = 2'd0;
    localparam logic [1:0] REQ_COORD_WR = 2'd1;
    localparam logic [1:0] REQ_LOOKUP   = 2'd2;

    // Request queue between the front end and the walk engine.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic [1:0] {
        CMD_NODE_WR,
        CMD_COORD_WR,
        CMD_LOOKUP
    } t_cmd_kind;

    // A checked request. The address and dimension are already 0-based.
    typedef struct packed {
        t_cmd_kind          kind;
        logic [10:0]        addr;
        logic [3:0]         dim;
        logic signed [31:0] value;
        logic signed [11:0] left;
        logic signed [11:0] right;
    } t_cmd;

    typedef struct packed {
        logic [3:0]         dim;
        logic signed [31:0] threshold;
        logic signed [11:0] left;
        logic signed [11:0] right;
    } t_node;

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic             status;
    } t_result;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_COORD,
        BK_EVAL
    } t_back_state;

endpackage

### design/tbl_front.sv
// ----------------------------------------------------------------------------
// tbl_front
// Unpacks incoming requests, checks node numbers and dimensions, drops
// requests that have no effect and hands the rest to the request queue.
// ----------------------------------------------------------------------------
module tbl_front #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_DIMS  = 8
) (
    input  logic                          i_valid,
    input  logic [tbl_pkg::IN_DATA_W-1:0] i_data,
    input  logic [tbl_pkg::IN_USER_W-1:0] i_user,
    input  logic                          i_q_ready,
    output logic                          o_ready,
    output logic                          o_push,
    output tbl_pkg::t_cmd                 o_cmd
);

    logic [10:0]        node_index;
    logic [3:0]         dim;
    logic signed [31:0] threshold;
    logic signed [11:0] left_child;
    logic signed [11:0] right_child;
    logic signed [31:0] coord_value;
    logic               idx_ok;
    logic               dim_ok;
    logic               keep;

    assign node_index  = i_data[10:0];
    assign dim         = i_data[14:11];
    assign threshold   = i_data[46:15];
    assign left_child  = i_data[58:47];
    assign right_child = i_data[70:59];
    assign coord_value = i_data[102:71];

    assign idx_ok = (node_index != 11'd0) && (32'(node_index) <= 32'(MAX_NODES));
    assign dim_ok = (dim != 4'd0) && (32'(dim) <= 32'(MAX_DIMS));

    always_comb begin
        o_cmd.addr  = node_index - 11'd1;
        o_cmd.dim   = dim - 4'd1;
        o_cmd.left  = left_child;
        o_cmd.right = right_child;
        o_cmd.value = threshold;
        unique case (i_user)
            tbl_pkg::REQ_NODE_WR: begin
                o_cmd.kind = tbl_pkg::CMD_NODE_WR;
                keep       = idx_ok && dim_ok;
            end
            tbl_pkg::REQ_COORD_WR: begin
                o_cmd.kind  = tbl_pkg::CMD_COORD_WR;
                o_cmd.value = coord_value;
                keep        = dim_ok;
            end
            tbl_pkg::REQ_LOOKUP: begin
                o_cmd.kind = tbl_pkg::CMD_LOOKUP;
                keep       = 1'b1;
            end
            default: begin
                // The unused request code is accepted and dropped.
                o_cmd.kind = tbl_pkg::CMD_LOOKUP;
                keep       = 1'b0;
            end
        endcase
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready && keep;

endmodule

### design/tbl_queue.sv
// ----------------------------------------------------------------------------
// tbl_queue
// Short request queue that decouples the front end from the walk engine.
// ----------------------------------------------------------------------------
module tbl_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tbl_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_ready,
    output logic          o_valid,
    output tbl_pkg::t_cmd o_head
);

    tbl_pkg::t_cmd                r_entries [tbl_pkg::QUEUE_DEPTH];
    logic [tbl_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [tbl_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [tbl_pkg::QUEUE_AW:0]   r_count;
    logic [tbl_pkg::QUEUE_AW:0]   n_count;

    assign o_ready = r_count != (tbl_pkg::QUEUE_AW + 1)'(tbl_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_entries[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### design/tbl_back.sv
// ----------------------------------------------------------------------------
// tbl_back
// Walk engine: owns the node and coordinate tables, applies table writes
// and walks the tree for lookups, each level a coordinate read and a branch decision.
// ----------------------------------------------------------------------------
`include "tree_bin_lookup_defines.svh"

module tbl_back #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_DIMS  = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  tbl_pkg::t_cmd    i_q_head,
    output logic             o_q_pop,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output tbl_pkg::t_result o_result
);

    localparam int NODE_AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int DIM_AW  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int STEP_W  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;

    tbl_pkg::t_node     r_node_mem  [MAX_NODES];
    logic signed [31:0] r_coord_mem [MAX_DIMS];

    tbl_pkg::t_back_state r_state;
    tbl_pkg::t_back_state n_state;
    logic [STEP_W-1:0]    r_steps;
    logic [STEP_W-1:0]    n_steps;
    logic                 r_out_valid;
    tbl_pkg::t_result     r_result;
    tbl_pkg::t_result     n_result;
    tbl_pkg::t_node       r_node_q;
    logic signed [31:0]   r_coord_q;

    logic                 node_we;
    logic                 coord_we;
    logic                 node_re;
    logic [NODE_AW-1:0]   node_raddr;
    logic                 coord_re;
    logic                 out_load;

    logic signed [11:0]   child;
    logic                 leaf;
    logic                 out_of_range;
    logic                 last_step;
    logic [12:0]          neg_child;
    logic [tbl_pkg::BIN_W-1:0] leaf_bin;

    // Branch decision on the registered node and coordinate reads.
    assign child        = (r_coord_q <= r_node_q.threshold) ? r_node_q.left : r_node_q.right;
    assign leaf         = child[11] || (child == 12'sd0);
    assign out_of_range = 32'($unsigned(child)) > 32'(MAX_NODES);
    assign last_step    = r_steps == STEP_W'(MAX_NODES - 1);
    assign neg_child    = 13'd0 - {child[11], child};
    // Only a child of -2048 sets bit 11; that bin saturates.
    assign leaf_bin     = neg_child[11] ? '1 : neg_child[10:0];

    always_comb begin
        n_state    = r_state;
        n_steps    = r_steps;
        n_result   = r_result;
        o_q_pop    = 1'b0;
        node_we    = 1'b0;
        coord_we   = 1'b0;
        node_re    = 1'b0;
        node_raddr = '0;
        coord_re   = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            tbl_pkg::BK_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    unique case (i_q_head.kind)
                        tbl_pkg::CMD_NODE_WR:  node_we  = 1'b1;
                        tbl_pkg::CMD_COORD_WR: coord_we = 1'b1;
                        tbl_pkg::CMD_LOOKUP: begin
                            // Every walk starts at node 1.
                            node_re = 1'b1;
                            n_steps = '0;
                            n_state = tbl_pkg::BK_COORD;
                        end
                        default: ;
                    endcase
                end
            end
            tbl_pkg::BK_COORD: begin
                coord_re = 1'b1;
                n_state  = tbl_pkg::BK_EVAL;
            end
            tbl_pkg::BK_EVAL: begin
                if (leaf || out_of_range || last_step) begin
                    if (!r_out_valid || i_out_ready) begin
                        out_load        = 1'b1;
                        n_result.bin    = leaf ? leaf_bin : '0;
                        n_result.status = !leaf;
                        n_state         = tbl_pkg::BK_IDLE;
                    end
                end else begin
                    node_re    = 1'b1;
                    node_raddr = NODE_AW'($unsigned(child - 12'sd1));
                    n_steps    = r_steps + 1'b1;
                    n_state    = tbl_pkg::BK_COORD;
                end
            end
            default: n_state = tbl_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tbl_pkg::BK_IDLE;
            r_steps     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_steps <= n_steps;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    // Node table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (node_we) begin
            r_node_mem[NODE_AW'(i_q_head.addr)] <= '{dim:       i_q_head.dim,
                                                     threshold: i_q_head.value,
                                                     left:      i_q_head.left,
                                                     right:     i_q_head.right};
        end
        if (node_re) begin
            r_node_q <= r_node_mem[node_raddr];
        end
    end

    // Coordinate table: written at the request dimension, read at the split dimension of the fetched node.
    always_ff @(posedge i_clk) begin
        if (coord_we) begin
            r_coord_mem[DIM_AW'(i_q_head.dim)] <= i_q_head.value;
        end
        if (coord_re) begin
            r_coord_q <= r_coord_mem[DIM_AW'(r_node_q.dim)];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    `TBL_ASSERT_IMPL(a_fault_bin_zero, i_clk, i_rst_n, r_out_valid && r_result.status, r_result.bin == '0, "walk fault result carries a nonzero bin")
    `TBL_ASSERT_IMPL(a_read_in_range, i_clk, i_rst_n, node_re, 32'(node_raddr) < 32'(MAX_NODES), "node read beyond the table")
    `TBL_ASSERT_NEXT(a_coord_then_eval, i_clk, i_rst_n, r_state == tbl_pkg::BK_COORD, r_state == tbl_pkg::BK_EVAL, "coordinate fetch not followed by evaluation")
    `TBL_ASSERT_IMPL(a_load_when_free, i_clk, i_rst_n, out_load, !r_out_valid || i_out_ready, "result overwrites an unread result")
    `TBL_ASSERT_IMPL(a_pop_when_valid, i_clk, i_rst_n, o_q_pop, i_q_valid, "pop from an empty request queue")

endmodule

### design/tree_bin_lookup.sv
// ----------------------------------------------------------------------------
// tree_bin_lookup
// Binary split tree bin lookup over signed Q16.16 values.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel; tuser selects a node write, a
// coordinate write or a lookup. Node numbers and dimensions are checked on
// entry and requests that cannot take effect are dropped there. Checked
// requests wait in a four-entry queue, so the input keeps accepting while a
// walk is in progress or the result is stalled, until that queue fills.
// The walk engine applies a write as it pops it. A lookup returns one result on
// m_axis: the bin in tdata and a fault flag in tuser. The walk engine first
// pops the queue and reads the root node; each level then takes a coordinate
// table read of the split dimension and a step that decides the branch and
// reads the next node. A finished walk waits there while the output register
// holds an unread result, and queued lookups wait until the walk ahead ends.
// The walk stops with a fault after MAX_NODES levels or at a child beyond
// the table. Results sit in an output register; while it is not taken the
// engine finishes writes but holds a finished walk. Reset empties the queue
// and the output register; the tables keep their contents and must be
// written before they are used.
// ----------------------------------------------------------------------------
module tree_bin_lookup #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_DIMS  = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // node_index[10:0], dim[14:11], threshold[46:15], left_child[58:47],
    // right_child[70:59], coord_value[102:71], zero pad[103]
    input  logic [tbl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // req_type[1:0]
    input  logic [tbl_pkg::IN_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // bin_index[10:0], zero pad[15:11]
    output logic [tbl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status[0]
    output logic                           m_axis_tuser
);

    logic             q_ready;
    logic             q_push;
    logic             q_valid;
    logic             q_pop;
    tbl_pkg::t_cmd    push_cmd;
    tbl_pkg::t_cmd    head_cmd;
    tbl_pkg::t_result result;

    tbl_front #(
        .MAX_NODES (MAX_NODES),
        .MAX_DIMS  (MAX_DIMS)
    ) u_front (
        .i_valid   (s_axis_tvalid),
        .i_data    (s_axis_tdata),
        .i_user    (s_axis_tuser),
        .i_q_ready (q_ready),
        .o_ready   (s_axis_tready),
        .o_push    (q_push),
        .o_cmd     (push_cmd)
    );

    tbl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_head  (head_cmd)
    );

    tbl_back #(
        .MAX_NODES (MAX_NODES),
        .MAX_DIMS  (MAX_DIMS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_head    (head_cmd),
        .o_q_pop     (q_pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_result    (result)
    );

    assign m_axis_tdata = {(tbl_pkg::OUT_DATA_W - tbl_pkg::BIN_W)'(0), result.bin};
    assign m_axis_tuser = result.status;

endmodule
